// ===== rtl/lzfg_pkg.sv =====
`timescale 1ns / 1ps

package lzfg_pkg;

   localparam int BYTE_W            = 8;
   localparam int CODE_W            = 16;
   localparam int GROUP_ITEMS       = 8;
   localparam int ITEMS_W           = 4;
   localparam int WINDOW_DEPTH_DEF  = 4096;
   localparam int LENGTH_BITS_DEF   = 4;

   // block sequencer
   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_REDUCE = 5'b00100,
      S_ADDR   = 5'b01000,
      S_COPY   = 5'b10000
   } state_type;

   // what the next packed byte means
   typedef enum logic [2:0] {
      P_FLAG = 3'b001,
      P_ITEM = 3'b010,
      P_PAIR = 3'b100
   } phase_type;

endpackage

// ===== rtl/lzfg_req_if.sv =====
`timescale 1ns / 1ps

interface lzfg_req_if
   import lzfg_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/lzfg_rsp_if.sv =====
`timescale 1ns / 1ps

interface lzfg_rsp_if
   import lzfg_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_end;

   modport source (output valid, output out_byte, output out_end, input ready);
   modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

// ===== rtl/lzfg_ram.sv =====
`timescale 1ns / 1ps

module lzfg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lzss_flag_group_decompressor.sv =====
`timescale 1ns / 1ps
// Flag, literal and pair high byte are each taken in S_IDLE; a literal shows on rsp the next cycle.
// Pair low byte: accepted, then S_REDUCE subtracts WINDOW_DEPTH R times, S_ADDR forms the read
// address and S_COPY sends 2 to 2**LENGTH_BITS+1 bytes, R = distance / WINDOW_DEPTH (0, or 1 at
// full distance by default). One history RAM port pair, so a pair copies one byte per cycle while
// rsp is not stalled. Reset (synchronous): control cleared, then a clearing pass over every history
// address zeroes the history before the first word is taken.

module lzss_flag_group_decompressor
   import lzfg_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lzfg_req_if.sink   req_chan,
   lzfg_rsp_if.source rsp_chan
);

   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int DIST_W = CODE_W - LENGTH_BITS + 1;
   localparam int WW     = (DIST_W > AW + 1) ? DIST_W : AW + 1;
   localparam int CNT_W  = LENGTH_BITS + 1;
   localparam logic [WW-1:0] DEPTH_W   = WW'(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   flag_bits_ff, flag_bits_in;
   logic [ITEMS_W-1:0]  items_left_ff, items_left_in;
   logic [BYTE_W-1:0]   pair_high_ff, pair_high_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [WW-1:0]       dist_ff, dist_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                byp_ff, byp_in;
   logic [BYTE_W-1:0]   byp_data_ff;

   logic                out_free, req_ready, accept, emit;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]   ram_wdata, ram_q, hist_q;
   logic [CODE_W-1:0]   code;
   logic [WW-1:0]       wp_ext;
   logic [AW-1:0]       rd_calc, cur_inc, wp_inc;
   logic [ITEMS_W-1:0]  il_dec;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_chan.valid && req_ready;
   assign emit      = (state_ff == S_COPY) && out_free;

   assign code    = {pair_high_ff, req_chan.in_byte};
   assign wp_ext  = WW'(wp_ff);
   assign rd_calc = (wp_ext < dist_ff) ? AW'(wp_ext + DEPTH_W - dist_ff) : AW'(wp_ext - dist_ff);
   assign cur_inc = (cur_ff == LAST_ADDR) ? '0 : cur_ff + 1'b1;
   assign wp_inc  = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
   assign il_dec  = (items_left_ff != '0) ? items_left_ff - 1'b1 : '0;

   // read straight after a write to the same slot sees the new byte
   assign hist_q = byp_ff ? byp_data_ff : ram_q;

   lzfg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      items_left_in = items_left_ff;
      pair_high_in  = pair_high_ff;
      wp_in         = wp_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      dist_in       = dist_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_end_in    = rsp_end_ff;
      ram_we        = 1'b0;
      ram_waddr     = wp_ff;
      ram_wdata     = req_chan.in_byte;
      ram_raddr     = cur_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (phase_ff)
                  P_FLAG: begin
                     flag_bits_in  = req_chan.in_byte;
                     items_left_in = ITEMS_W'(GROUP_ITEMS);
                     phase_in      = P_ITEM;
                  end
                  P_ITEM: begin
                     if (!flag_bits_ff[BYTE_W-1]) begin
                        ram_we        = 1'b1;
                        wp_in         = wp_inc;
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = req_chan.in_byte;
                        rsp_end_in    = 1'b1;
                        flag_bits_in  = {flag_bits_ff[BYTE_W-2:0], 1'b0};
                        items_left_in = il_dec;
                        phase_in      = (il_dec == '0) ? P_FLAG : P_ITEM;
                     end else begin
                        pair_high_in = req_chan.in_byte;
                        phase_in     = P_PAIR;
                     end
                  end
                  P_PAIR: begin
                     dist_in       = WW'(code[CODE_W-1:LENGTH_BITS]) + 1'b1;
                     cnt_in        = CNT_W'(code[LENGTH_BITS-1:0]) + 1'b1;
                     state_in      = S_REDUCE;
                     flag_bits_in  = {flag_bits_ff[BYTE_W-2:0], 1'b0};
                     items_left_in = il_dec;
                     phase_in      = (il_dec == '0) ? P_FLAG : P_ITEM;
                  end
                  default: begin
                     phase_in = P_FLAG;
                  end
               endcase
               if (req_chan.in_last) begin
                  phase_in      = P_FLAG;
                  flag_bits_in  = '0;
                  items_left_in = '0;
               end
            end
         end
         S_REDUCE: begin
            // distance modulo window depth, one subtraction a cycle
            if (dist_ff >= DEPTH_W) begin
               dist_in = dist_ff - DEPTH_W;
            end else begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            ram_raddr = rd_calc;
            cur_in    = rd_calc;
            state_in  = S_COPY;
         end
         S_COPY: begin
            if (emit) begin
               ram_raddr    = cur_inc;
               cur_in       = cur_inc;
               ram_we       = 1'b1;
               ram_wdata    = hist_q;
               wp_in        = wp_inc;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hist_q;
               rsp_end_in   = (cnt_ff == '0);
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign byp_in = ram_we && (ram_waddr == ram_raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         phase_ff      <= P_FLAG;
         flag_bits_ff  <= '0;
         items_left_ff <= '0;
         pair_high_ff  <= '0;
         wp_ff         <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         byp_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         items_left_ff <= items_left_in;
         pair_high_ff  <= pair_high_in;
         wp_ff         <= wp_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         byp_ff        <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      dist_ff     <= dist_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      byp_data_ff <= ram_wdata;
   end

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_end  = rsp_end_ff;

`ifndef SYNTH
   a_no_word_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("rsp word during history clear");

   a_copy_ends_idle: assert property (@(posedge clock) disable iff (reset)
      emit && cnt_ff == '0 |=> state_ff == S_IDLE && rsp_valid_ff && rsp_end_ff)
      else $error("copy did not finish on its last byte");

   a_items_bound: assert property (@(posedge clock) disable iff (reset)
      items_left_ff <= ITEMS_W'(GROUP_ITEMS))
      else $error("items_left beyond one flag group");

   a_pair_needs_flag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == P_PAIR |-> flag_bits_ff[BYTE_W-1] && items_left_ff != '0)
      else $error("pair phase without a set flag");
`endif

endmodule
